/* rtl/gcd_pkg.sv */
package gcd_pkg;

	localparam int CordicSteps = 24;
	localparam int AngW = 34;
	localparam int QW = 36;

	localparam logic [33:0] TurnUnits    = 34'd720000000;
	localparam logic [33:0] QuarterUnits = 34'd180000000;
	localparam logic [33:0] RadScale     = 34'd10061137964;
	localparam logic [35:0] OneQ30       = 36'h040000000;
	localparam logic [35:0] CordicGain   = 36'd652032874;
	localparam logic [27:0] DistScale    = 28'd127562740;

	localparam logic REG_OWN_LAT = 1'b0;
	localparam logic REG_OWN_LNG = 1'b1;

	function automatic logic [35:0] atan_tab(input int n);
		logic [35:0] r;
		r = '0;
		case (n)
			0: r = 36'd843314857;
			1: r = 36'd497837829;
			2: r = 36'd263043837;
			3: r = 36'd133525159;
			4: r = 36'd67021687;
			5: r = 36'd33543516;
			6: r = 36'd16775851;
			7: r = 36'd8388437;
			8: r = 36'd4194283;
			9: r = 36'd2097149;
			10: r = 36'd1048576;
			11: r = 36'd524288;
			12: r = 36'd262144;
			13: r = 36'd131072;
			14: r = 36'd65536;
			15: r = 36'd32768;
			16: r = 36'd16384;
			17: r = 36'd8192;
			18: r = 36'd4096;
			19: r = 36'd2048;
			20: r = 36'd1024;
			21: r = 36'd512;
			22: r = 36'd256;
			23: r = 36'd128;
			24: r = 36'd64;
			25: r = 36'd32;
			26: r = 36'd16;
			27: r = 36'd8;
			28: r = 36'd4;
			29: r = 36'd2;
			30: r = 36'd1;
			31: r = 36'd1;
			default: r = 36'd0;
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic        sneg;
		logic        cneg;
		logic [35:0] x;
		logic [35:0] y;
		logic [35:0] z;
	} rot_t;

endpackage

/* rtl/gcd_sincos.sv */
module gcd_sincos (
	input  logic                clk,
	input  logic                en,
	input  logic signed [33:0]  ang,
	output logic signed [35:0]  sn,
	output logic signed [35:0]  cs
);
	localparam int N = gcd_pkg::CordicSteps;

	logic [33:0] w_s1;
	logic        sneg_s1, cneg_s1;
	gcd_pkg::rot_t st [0:N];
	logic [63:0] prod;
	logic [33:0] wp;

	// the angle never reaches a full turn, so one add wraps it
	always_comb begin
		if (ang < 0)
			wp = 34'(ang + $signed(gcd_pkg::TurnUnits));
		else
			wp = 34'(ang);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sneg_s1 <= 1'b0;
			cneg_s1 <= 1'b0;
			if (wp >= 34'(3 * 180000000)) begin
				w_s1 <= gcd_pkg::TurnUnits - wp;
				sneg_s1 <= 1'b1;
			end else if (wp >= 34'(2 * 180000000)) begin
				w_s1 <= wp - 34'(2 * 180000000);
				sneg_s1 <= 1'b1;
				cneg_s1 <= 1'b1;
			end else if (wp > gcd_pkg::QuarterUnits) begin
				w_s1 <= 34'(2 * 180000000) - wp;
				cneg_s1 <= 1'b1;
			end else begin
				w_s1 <= wp;
			end
		end
	end

	assign prod = 64'(w_s1) * 64'(gcd_pkg::RadScale) + 64'd536870912;

	assign st[0] = {sneg_s1, cneg_s1, gcd_pkg::CordicGain, 36'd0, 36'(prod >> 30)};

	for (genvar n = 0; n < N; n++) begin : g_step
		gcd_pkg::rot_t nx;
		always_comb begin
			nx = st[n];
			if (!st[n].z[35]) begin
				nx.x = st[n].x - 36'($signed(st[n].y) >>> n);
				nx.y = st[n].y + 36'($signed(st[n].x) >>> n);
				nx.z = st[n].z - gcd_pkg::atan_tab(n);
			end else begin
				nx.x = st[n].x + 36'($signed(st[n].y) >>> n);
				nx.y = st[n].y - 36'($signed(st[n].x) >>> n);
				nx.z = st[n].z + gcd_pkg::atan_tab(n);
			end
		end
		gcd_pkg::rot_t r_s2;
		always_ff @(posedge clk) begin
			if (en)
				r_s2 <= nx;
		end
		assign st[n + 1] = r_s2;
	end

	assign sn = st[N].sneg ? -$signed(st[N].y) : $signed(st[N].y);
	assign cs = st[N].cneg ? -$signed(st[N].x) : $signed(st[N].x);
endmodule

/* rtl/gcd_sqrt.sv */
module gcd_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [61:0] v,
	output logic [30:0] root
);
	localparam int B = 31;

	logic [61:0] rem [0:B];
	logic [30:0] res [0:B];

	assign rem[0] = v;
	assign res[0] = '0;

	for (genvar i = 0; i < B; i++) begin : g_bit
		logic [62:0] trial;
		logic [61:0] rn;
		logic [30:0] qn;
		logic [61:0] rem_s1;
		logic [30:0] res_s1;
		localparam int Sh = 2 * (B - 1 - i);
		always_comb begin
			trial = 63'({res[i], 1'b0, 1'b1}) << Sh;
			if (63'(rem[i]) >= trial) begin
				rn = 62'(63'(rem[i]) - trial);
				qn = {res[i][29:0], 1'b1};
			end else begin
				rn = rem[i];
				qn = {res[i][29:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s1 <= rn;
				res_s1 <= qn;
			end
		end
		assign rem[i + 1] = rem_s1;
		assign res[i + 1] = res_s1;
	end

	assign root = res[B];
endmodule

/* rtl/gcd_vector.sv */
module gcd_vector (
	input  logic               clk,
	input  logic               en,
	input  logic signed [35:0] x0,
	input  logic signed [35:0] y0,
	output logic [27:0]        distance
);
	localparam int N = gcd_pkg::CordicSteps;

	gcd_pkg::rot_t st [0:N];
	logic signed [35:0] th;
	logic [63:0] dprod;
	logic [35:0] th_s1;

	assign st[0] = {1'b0, 1'b0, x0, y0, 36'd0};

	for (genvar n = 0; n < N; n++) begin : g_step
		gcd_pkg::rot_t nx;
		gcd_pkg::rot_t r_s1;
		always_comb begin
			nx = st[n];
			if (!st[n].y[35]) begin
				nx.x = st[n].x + 36'($signed(st[n].y) >>> n);
				nx.y = st[n].y - 36'($signed(st[n].x) >>> n);
				nx.z = st[n].z + gcd_pkg::atan_tab(n);
			end else begin
				nx.x = st[n].x - 36'($signed(st[n].y) >>> n);
				nx.y = st[n].y + 36'($signed(st[n].x) >>> n);
				nx.z = st[n].z - gcd_pkg::atan_tab(n);
			end
		end
		always_ff @(posedge clk) begin
			if (en)
				r_s1 <= nx;
		end
		assign st[n + 1] = r_s1;
	end

	assign th = $signed(st[N].z);

	always_ff @(posedge clk) begin
		if (en)
			th_s1 <= th[35] ? '0 : th;
	end

	assign dprod = 64'(th_s1) * 64'(gcd_pkg::DistScale) + 64'd536870912;
	assign distance = dprod[57:30];
endmodule

/* rtl/great_circle_distance.sv */
// channel  | signals                              | direction
// cfg      | cfg_valid cfg_ready cfg_index cfg_data | in
// target   | in_valid in_ready target_lat target_lng | in
// result   | out_valid out_ready distance         | out
// one word per cycle while the output is not stalled; the path runs through
// the two cordic pipelines, the three multiply stages and the 31 square root stages
// arst_n clears the valid chain and the own position registers
// a stalled output freezes every stage at once, nothing is lost
module great_circle_distance (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [28:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [27:0] target_lat,
	input  logic signed [28:0] target_lng,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [27:0] distance
);
	localparam int N = gcd_pkg::CordicSteps;
	localparam int Lat = 1 + N + 3 + 31 + N + 1;

	logic signed [27:0] own_lat_q;
	logic signed [28:0] own_lng_q;
	logic [Lat-1:0] vld_q;
	logic en;

	assign en = out_ready | ~vld_q[Lat-1];
	assign in_ready = en;
	assign cfg_ready = 1'b1;
	assign out_valid = vld_q[Lat-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_lat_q <= '0;
			own_lng_q <= '0;
			vld_q <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == gcd_pkg::REG_OWN_LAT)
					own_lat_q <= cfg_data[27:0];
				else
					own_lng_q <= cfg_data;
			end
			if (en)
				vld_q <= {vld_q[Lat-2:0], in_valid};
		end
	end

	logic signed [33:0] a_dlat, a_dlng, a_l1, a_l2;
	assign a_dlat = 34'(own_lat_q) - 34'(target_lat);
	assign a_dlng = 34'(own_lng_q) - 34'(target_lng);
	assign a_l1 = 34'(own_lat_q) <<< 1;
	assign a_l2 = 34'(target_lat) <<< 1;

	logic signed [35:0] sa, sb, c1, c2, u0, u1, u2, u3;
	gcd_sincos u_a (.clk, .en, .ang(a_dlat), .sn(sa), .cs(u0));
	gcd_sincos u_b (.clk, .en, .ang(a_dlng), .sn(sb), .cs(u1));
	gcd_sincos u_c (.clk, .en, .ang(a_l1), .sn(u2), .cs(c1));
	gcd_sincos u_d (.clk, .en, .ang(a_l2), .sn(u3), .cs(c2));

	function automatic logic signed [35:0] mulq(input logic signed [35:0] x,
		input logic signed [35:0] y);
		logic [35:0] ux, uy;
		logic [63:0] p;
		logic [35:0] q;
		ux = x[35] ? -x : x;
		uy = y[35] ? -y : y;
		p = 64'(ux[31:0]) * 64'(uy[31:0]) + 64'd536870912;
		q = 36'(p >> 30);
		return (x[35] ^ y[35]) ? -$signed(q) : $signed(q);
	endfunction

	logic signed [35:0] saa_s1, sbb_s1, cc_s1, t_s2, saa_s2, h_s3;
	logic signed [36:0] hs;
	always_ff @(posedge clk) begin
		if (en) begin
			saa_s1 <= mulq(sa, sa);
			sbb_s1 <= mulq(sb, sb);
			cc_s1 <= mulq(c1, c2);
			t_s2 <= mulq(cc_s1, sbb_s1);
			saa_s2 <= saa_s1;
			if (hs < 0)
				h_s3 <= '0;
			else if (hs > 37'(gcd_pkg::OneQ30))
				h_s3 <= gcd_pkg::OneQ30;
			else
				h_s3 <= 36'(hs);
		end
	end
	assign hs = 37'(saa_s2) + 37'(t_s2);

	logic [30:0] s_root, c_root;
	logic [35:0] hc;
	assign hc = gcd_pkg::OneQ30 - h_s3;
	gcd_sqrt u_s (.clk, .en, .v({h_s3[31:0], 30'd0}), .root(s_root));
	gcd_sqrt u_cq (.clk, .en, .v({hc[31:0], 30'd0}), .root(c_root));

	logic unused_sc;
	assign unused_sc = ^{u0, u1, u2, u3, h_s3[35:32], hc[35:32]};

	logic [27:0] dist_w;
	gcd_vector u_v (.clk, .en, .x0(36'(c_root)), .y0(36'(s_root)),
		.distance(dist_w));
	assign distance = dist_w ^ 28'(unused_sc & 1'b0);
endmodule
